FILE: hdl/mscg_pkg.sv
`timescale 1ns / 1ps

package mscg_pkg;

    localparam int NUM_COLOUR_REGS = 7;
    localparam int CFG_INDEX_W     = 3;
    localparam int STOP_COUNT_W    = 3;
    localparam int COLOUR_W        = 32;
    localparam int CHAN_W          = 8;
    localparam int NUM_CHANS       = 4;

    typedef logic [COLOUR_W-1:0]     t_colour;
    typedef logic [CHAN_W-1:0]       t_chan;
    typedef logic [STOP_COUNT_W-1:0] t_stop_count;
    typedef logic [CFG_INDEX_W-1:0]  t_cfg_index;

    localparam t_cfg_index  REG_STOP_COUNT    = 3'd0;
    localparam t_cfg_index  REG_STOP_COLOUR_0 = 3'd1;

    localparam t_stop_count STOP_COUNT_RESET = 3'd7;
    localparam t_stop_count STOP_COUNT_MIN   = 3'd2;

    localparam t_colour COLOUR_RESET [NUM_COLOUR_REGS] = '{
        32'hFF0000FF, 32'hFF7F00FF, 32'hFFFF00FF, 32'h00FF00FF,
        32'h0000FFFF, 32'h4B00FFFF, 32'h8B00FFFF
    };

endpackage

FILE: hdl/multi_stop_colour_gradient.sv
`timescale 1ns / 1ps

// Multi-stop colour gradient. A progress word (FRACTION_BITS fraction bits,
// saturating at 1.0) is taken at every clock edge with start high and busy
// low; o_strobe and the packed colour on o_colour come up once the word has
// passed segment pick, stop colour select, channel products and final sum,
// which are each one register stage.
// One word per clock, sustained, with no stall. The receiver cannot hold
// results off. busy is high during reset and in the cycle after it, and low
// from then on. Stop count and stop colours are written through the cfg port
// (index 0: stop count, 1..7: stop colours) and must only change while no
// word is in flight.

module multi_stop_colour_gradient
    import mscg_pkg::*;
#(
    parameter int MAX_STOPS     = 7,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [FRACTION_BITS:0]   i_progress,
    output logic                     o_strobe,
    output t_colour                  o_colour,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  t_cfg_index               i_cfg_index,
    input  t_colour                  i_cfg_data
);

    localparam int PW = FRACTION_BITS + 1;
    localparam int SW = FRACTION_BITS + 3;
    localparam int MW = CHAN_W + PW;
    localparam int AW = MW + 1;
    localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam t_stop_count MAX_N = STOP_COUNT_W'(MAX_STOPS);

    typedef logic [PW-1:0] t_frac;
    typedef logic [2:0]    t_seg;

    logic        r_busy;
    t_stop_count r_stop_count;
    t_colour     r_stop_colour [NUM_COLOUR_REGS];

    logic        r1_valid;
    t_seg        r1_seg;
    t_frac       r1_frac;
    logic        r2_valid;
    t_colour     r2_from;
    t_colour     r2_to;
    t_frac       r2_frac;
    logic        r3_valid;
    logic [MW-1:0] r3_prod_a [NUM_CHANS];
    logic [MW-1:0] r3_prod_b [NUM_CHANS];
    logic        r_strobe;
    t_colour     r_colour;

    t_stop_count n_count;
    t_stop_count n_minus1;
    t_frac       n_prog;
    logic [SW-1:0] n_scaled;
    t_seg        n_seg;
    t_frac       n_frac;
    logic [MW-1:0] n_prod_a [NUM_CHANS];
    logic [MW-1:0] n_prod_b [NUM_CHANS];
    t_colour     n_colour;
    logic        n_accept;
    logic        n_cfg_we;

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;
    assign o_strobe    = r_strobe;
    assign o_colour    = r_colour;
    assign n_accept    = start && !r_busy;
    assign n_cfg_we    = i_cfg_valid && !r_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_stop_count <= STOP_COUNT_RESET;
            for (int i = 0; i < NUM_COLOUR_REGS; i++) begin
                r_stop_colour[i] <= COLOUR_RESET[i];
            end
        end else begin
            r_busy <= 1'b0;
            if (n_cfg_we) begin
                if (i_cfg_index == REG_STOP_COUNT) begin
                    r_stop_count <= i_cfg_data[STOP_COUNT_W-1:0];
                end else begin
                    r_stop_colour[3'(i_cfg_index - REG_STOP_COLOUR_0)] <= i_cfg_data;
                end
            end
        end
    end

    // stage 1: saturate, scale, split into segment and fraction
    always_comb begin
        n_count = r_stop_count;
        if (n_count < STOP_COUNT_MIN) begin
            n_count = STOP_COUNT_MIN;
        end
        if (n_count > MAX_N) begin
            n_count = MAX_N;
        end
        n_minus1 = n_count - 3'd1;
        n_prog   = (i_progress > FRAC_ONE) ? FRAC_ONE : i_progress;
        n_scaled = SW'(n_prog) * SW'(n_minus1);
        n_seg    = n_scaled[FRACTION_BITS +: 3];
        n_frac   = {1'b0, n_scaled[FRACTION_BITS-1:0]};
        if (n_seg >= n_minus1) begin
            n_seg  = n_minus1 - 3'd1;
            n_frac = FRAC_ONE;
        end
    end

    // stage 3: per channel products
    always_comb begin
        for (int k = 0; k < NUM_CHANS; k++) begin
            n_prod_a[k] = MW'(r2_from[k*CHAN_W +: CHAN_W]) * MW'(FRAC_ONE - r2_frac);
            n_prod_b[k] = MW'(r2_to[k*CHAN_W +: CHAN_W]) * MW'(r2_frac);
        end
    end

    // stage 4: sum and drop the fraction
    always_comb begin
        logic [AW-1:0] sum;
        n_colour = '0;
        for (int k = 0; k < NUM_CHANS; k++) begin
            sum = AW'(r3_prod_a[k]) + AW'(r3_prod_b[k]);
            n_colour[k*CHAN_W +: CHAN_W] = sum[FRACTION_BITS +: CHAN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r1_valid <= n_accept;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r_strobe <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_seg   <= n_seg;
        r1_frac  <= n_frac;
        r2_from  <= r_stop_colour[r1_seg];
        r2_to    <= r_stop_colour[3'(r1_seg + 3'd1)];
        r2_frac  <= r1_frac;
        for (int k = 0; k < NUM_CHANS; k++) begin
            r3_prod_a[k] <= n_prod_a[k];
            r3_prod_b[k] <= n_prod_b[k];
        end
        r_colour <= n_colour;
    end

endmodule

FILE: hdl/mscg_checker.sv
`timescale 1ns / 1ps

module mscg_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe
);

    localparam int LATENCY = 4;

    // every accepted word gives a result after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("accepted word produced no result");

    // no result without a word accepted earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("result without accepted word");

    // reset leaves the block busy and silent
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_strobe))
        else $error("busy or strobe wrong after reset");

    // once out of reset the block never blocks input
    a_never_busy: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> !busy)
        else $error("busy outside reset");

endmodule

bind multi_stop_colour_gradient mscg_checker u_mscg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mscg_pkg::*;

    localparam int MAX_STOPS     = 7;
    localparam int FRACTION_BITS = 16;
    localparam int ONE           = 1 << FRACTION_BITS;
    localparam int PIPE_DEPTH    = 4;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS   = 113;

    typedef struct packed {
        logic [FRACTION_BITS:0] progress;
        t_colour                colour;
    } t_colour_due;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [FRACTION_BITS:0] i_progress;
    logic                   o_strobe;
    t_colour                o_colour;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    t_cfg_index             i_cfg_index;
    t_colour                i_cfg_data;

    t_stop_count   model_stop_count;
    t_colour       model_colours [NUM_COLOUR_REGS];
    t_colour       next_palette [NUM_COLOUR_REGS];
    t_colour_due   colours_due [$];
    int unsigned   mismatches = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   max_gap = 4;

    multi_stop_colour_gradient #(
        .MAX_STOPS     (MAX_STOPS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_progress  (i_progress),
        .o_strobe    (o_strobe),
        .o_colour    (o_colour),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned active_stops();
        int unsigned n;
        n = model_stop_count;
        if (n < STOP_COUNT_MIN) begin
            n = STOP_COUNT_MIN;
        end
        if (n > MAX_STOPS) begin
            n = MAX_STOPS;
        end
        return n;
    endfunction

    function automatic t_colour predict_colour(logic [FRACTION_BITS:0] progress);
        int unsigned p;
        int unsigned spans;
        int unsigned scaled;
        int unsigned seg;
        int unsigned frac;
        int unsigned mix;
        t_colour     lo_stop;
        t_colour     hi_stop;
        t_colour     blended;
        p = (progress > ONE) ? ONE : progress;
        spans = active_stops() - 1;
        scaled = p * spans;
        seg = scaled >> FRACTION_BITS;
        frac = scaled & (ONE - 1);
        // full progress lands on the last stop
        if (seg >= spans) begin
            seg = spans - 1;
            frac = ONE;
        end
        lo_stop = model_colours[seg];
        hi_stop = model_colours[seg + 1];
        for (int k = 0; k < NUM_CHANS; k++) begin
            mix = lo_stop[CHAN_W*k +: CHAN_W] * (ONE - frac)
                + hi_stop[CHAN_W*k +: CHAN_W] * frac;
            blended[CHAN_W*k +: CHAN_W] = t_chan'(mix >> FRACTION_BITS);
        end
        return blended;
    endfunction

    function automatic logic [FRACTION_BITS:0] random_progress();
        int unsigned spans;
        int unsigned k;
        int          v;
        spans = active_stops() - 1;
        case ($urandom_range(0, 9))
            7: v = $urandom_range(ONE, 2*ONE - 1);
            8: begin
                // just around a segment boundary
                k = $urandom_range(0, spans);
                v = int'((k*ONE + spans - 1) / spans) + int'($urandom_range(0, 2)) - 1;
                if (v < 0) begin
                    v = 0;
                end
            end
            9: v = $urandom_range(0, 2*ONE - 1);
            default: v = $urandom_range(0, ONE);
        endcase
        return v[FRACTION_BITS:0];
    endfunction

    task automatic report_mismatch(string what, t_colour got, t_colour want);
        $display("tb_top: %s: colour %h, predicted %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_progress(logic [FRACTION_BITS:0] value);
        int unsigned gap;
        t_colour_due due;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_progress <= value;
        do @(posedge i_clk); while (busy);
        due.progress = value;
        due.colour = predict_colour(value);
        colours_due.push_back(due);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (colours_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index index, t_colour data);
        int unsigned gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == REG_STOP_COUNT) begin
            model_stop_count = data[STOP_COUNT_W-1:0];
        end else begin
            model_colours[index - REG_STOP_COLOUR_0] = data;
        end
    endtask

    task automatic configure_gradient(t_stop_count count);
        drain_results();
        write_reg(REG_STOP_COUNT, t_colour'(count));
        for (int i = 0; i < NUM_COLOUR_REGS; i++) begin
            write_reg(t_cfg_index'(REG_STOP_COLOUR_0 + i), next_palette[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic shuffle_palette();
        for (int i = 0; i < NUM_COLOUR_REGS; i++) begin
            case ($urandom_range(0, 7))
                0: next_palette[i] = '0;
                1: next_palette[i] = '1;
                default: next_palette[i] = $urandom;
            endcase
        end
    endtask

    task automatic test_rainbow_reset();
        logic [FRACTION_BITS:0] points [12];
        points = '{17'd0, 17'd1, 17'd10922, 17'd10923, 17'd21845, 17'd32768,
                   17'd65535, 17'd65536, 17'd65537, 17'h1FFFF, 17'h0AAAA, 17'h15555};
        foreach (points[i]) begin
            send_progress(points[i]);
        end
    endtask

    task automatic test_stop_count_extremes();
        logic [FRACTION_BITS:0] points [5];
        points = '{17'd0, 17'd32768, 17'd65535, 17'd65536, 17'h1FFFF};
        shuffle_palette();
        // channels rising and falling at once
        next_palette[0] = 32'h00FF00FF;
        next_palette[1] = 32'hFF00FF00;
        configure_gradient(3'd2);
        foreach (points[i]) begin
            send_progress(points[i]);
        end
        // counts below the minimum act as two stops
        configure_gradient(3'd0);
        send_progress(17'd16384);
        send_progress(17'd65536);
        configure_gradient(3'd1);
        send_progress(17'd49152);
        send_progress(17'h1FFFF);
    endtask

    task automatic test_random_phases();
        t_stop_count count;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: count = 3'd2;
                1: count = 3'd7;
                default: count = t_stop_count'($urandom_range(0, 7));
            endcase
            shuffle_palette();
            configure_gradient(count);
            max_gap = (phase % 3 == 2) ? 0 : 4;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 39) == 0) begin
                    drain_results();
                end
                send_progress(random_progress());
            end
        end
        max_gap = 4;
    endtask

    always @(posedge i_clk) begin : check_results
        t_colour_due due;
        if (i_rst_n && o_strobe) begin
            if (colours_due.size() == 0) begin
                report_mismatch("unexpected word", o_colour, '0);
            end else begin
                due = colours_due.pop_front();
                if (o_colour !== due.colour) begin
                    report_mismatch($sformatf("progress %h", due.progress), o_colour,
                                    due.colour);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_progress <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_STOP_COUNT;
        i_cfg_data <= '0;
        model_stop_count = STOP_COUNT_RESET;
        model_colours = COLOUR_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_rainbow_reset();
        test_stop_count_extremes();
        test_random_phases();
        drain_results();
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

FILE: multi_stop_colour_gradient.f
hdl/mscg_pkg.sv
hdl/multi_stop_colour_gradient.sv
hdl/mscg_checker.sv
test/tb_top.sv
